### hdl/stereo_crossfeed_mixer_top_macros.svh
// Assertion macros shared by the crossfeed mixer RTL.
// Each macro checks on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef STEREO_CROSSFEED_MIXER_TOP_MACROS_SVH
`define STEREO_CROSSFEED_MIXER_TOP_MACROS_SVH

// Same-cycle implication.
`define SFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sfm_pkg.sv
// Package for the stereo crossfeed mixer: widths, register map, sequencer states,
// shared operand types and the round-and-saturate function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfm_pkg;

  localparam int unsigned SampleWidth = 24;
  localparam int unsigned DelayDepth  = 64;
  localparam int unsigned PtrW        = $clog2(DelayDepth);
  localparam int unsigned CoefW       = 17;
  localparam int unsigned AccW        = SampleWidth + CoefW + 1;
  localparam int unsigned NumRegs     = 7;
  localparam int unsigned AddrW       = $clog2(NumRegs * 4);
  localparam int unsigned DataW       = 32;
  localparam int unsigned MixW        = 16;
  localparam int unsigned MixFull     = 65535;
  localparam int unsigned MixScale    = 65536;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [AccW-1:0]        acc_t;
  typedef logic [CoefW-1:0]              coef_t;
  typedef logic [PtrW-1:0]               ptr_t;
  typedef logic [2*SampleWidth-1:0]      line_word_t;

  localparam acc_t SampleMax = acc_t'((64'd1 << (SampleWidth - 1)) - 64'd1);
  localparam acc_t SampleMin = -SampleMax - acc_t'(1);

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_DIRECT_GAIN = 3'd1,
    REG_CROSS_GAIN  = 3'd2,
    REG_LP_GAIN     = 3'd3,
    REG_LP_POLE     = 3'd4,
    REG_DELAY       = 3'd5,
    REG_RAMP_COEFF  = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LP,
    S_LP_SAT,
    S_WET,
    S_WET_SAT,
    S_BLEND,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        enable;
    logic [15:0] direct_gain;
    logic [15:0] cross_gain;
    logic [15:0] lowpass_input_gain;
    logic [14:0] lowpass_pole;
    logic [5:0]  delay_frames;
    logic [15:0] ramp_coeff;
  } cfg_t;

  typedef struct packed {
    coef_t   coef_a;
    sample_t smp_a;
    coef_t   coef_b;
    sample_t smp_b;
  } mac_op_t;

  function automatic sample_t round_sat(input acc_t acc, input int unsigned shift);
    acc_t t;
    t = (acc + (acc_t'(1) <<< (shift - 1))) >>> shift;
    if (t > SampleMax) begin
      return sample_t'(SampleMax);
    end else if (t < SampleMin) begin
      return sample_t'(SampleMin);
    end
    return sample_t'(t);
  endfunction

endpackage

`default_nettype wire

### hdl/sfm_in_if.sv
// Input stream interface of the crossfeed mixer: one stereo frame per transfer.
// Depends on sfm_pkg for the sample type.
`timescale 1ns / 1ps
`default_nettype none

interface sfm_in_if;
  logic             valid;
  logic             ready;
  sfm_pkg::sample_t left_in;
  sfm_pkg::sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

### hdl/sfm_out_if.sv
// Output stream interface of the crossfeed mixer: one stereo frame per transfer.
// Depends on sfm_pkg for the sample type.
`timescale 1ns / 1ps
`default_nettype none

interface sfm_out_if;
  logic             valid;
  logic             ready;
  sfm_pkg::sample_t left_out;
  sfm_pkg::sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

### hdl/sfm_regs.sv
// APB configuration registers of the crossfeed mixer.
// Depends on sfm_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module sfm_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel_i,
  input  wire logic                      penable_i,
  input  wire logic                      pwrite_i,
  input  wire logic [sfm_pkg::AddrW-1:0] paddr_i,
  input  wire logic [sfm_pkg::DataW-1:0] pwdata_i,
  output logic      [sfm_pkg::DataW-1:0] prdata_o,
  output logic                           pready_o,
  output sfm_pkg::cfg_t                  cfg_o
);

  sfm_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx      = paddr_i[sfm_pkg::AddrW-1:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable             <= 1'b0;
      cfg_q.direct_gain        <= 16'd32768;
      cfg_q.cross_gain         <= 16'd0;
      cfg_q.lowpass_input_gain <= 16'd32768;
      cfg_q.lowpass_pole       <= 15'd0;
      cfg_q.delay_frames       <= 6'd0;
      cfg_q.ramp_coeff         <= 16'd4096;
    end else if (wr_en) begin
      case (idx)
        sfm_pkg::REG_ENABLE:      cfg_q.enable             <= pwdata_i[0];
        sfm_pkg::REG_DIRECT_GAIN: cfg_q.direct_gain        <= pwdata_i[15:0];
        sfm_pkg::REG_CROSS_GAIN:  cfg_q.cross_gain         <= pwdata_i[15:0];
        sfm_pkg::REG_LP_GAIN:     cfg_q.lowpass_input_gain <= pwdata_i[15:0];
        sfm_pkg::REG_LP_POLE:     cfg_q.lowpass_pole       <= pwdata_i[14:0];
        sfm_pkg::REG_DELAY:       cfg_q.delay_frames       <= pwdata_i[5:0];
        sfm_pkg::REG_RAMP_COEFF:  cfg_q.ramp_coeff         <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sfm_pkg::REG_ENABLE:      prdata_o = {31'd0, cfg_q.enable};
      sfm_pkg::REG_DIRECT_GAIN: prdata_o = {16'd0, cfg_q.direct_gain};
      sfm_pkg::REG_CROSS_GAIN:  prdata_o = {16'd0, cfg_q.cross_gain};
      sfm_pkg::REG_LP_GAIN:     prdata_o = {16'd0, cfg_q.lowpass_input_gain};
      sfm_pkg::REG_LP_POLE:     prdata_o = {17'd0, cfg_q.lowpass_pole};
      sfm_pkg::REG_DELAY:       prdata_o = {26'd0, cfg_q.delay_frames};
      sfm_pkg::REG_RAMP_COEFF:  prdata_o = {16'd0, cfg_q.ramp_coeff};
      default:                  prdata_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/sfm_delay_ram.sv
// Single-port delay line memory holding both cross paths, one frame per word.
// Entries never written read as zero through per-entry valid bits; depends on sfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfm_delay_ram (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                we_i,
  input  wire sfm_pkg::ptr_t       addr_i,
  input  wire sfm_pkg::line_word_t wdata_i,
  output sfm_pkg::line_word_t      rdata_o
);

  sfm_pkg::line_word_t            mem [sfm_pkg::DelayDepth];
  logic [sfm_pkg::DelayDepth-1:0] valid_q;
  sfm_pkg::line_word_t            rdata_q;
  logic                           rvalid_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (en_i && we_i) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (en_i && !we_i) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

### hdl/sfm_mac.sv
// Shared two-product multiply-accumulate unit with a registered sum.
// Depends on sfm_pkg for the operand struct and accumulator type.
`timescale 1ns / 1ps
`default_nettype none

module sfm_mac (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire sfm_pkg::mac_op_t op_i,
  output sfm_pkg::acc_t         acc_o
);

  logic signed [sfm_pkg::CoefW:0] coef_a;
  logic signed [sfm_pkg::CoefW:0] coef_b;
  sfm_pkg::acc_t                  prod_a;
  sfm_pkg::acc_t                  prod_b;
  sfm_pkg::acc_t                  acc_q;

  assign coef_a = $signed({1'b0, op_i.coef_a});
  assign coef_b = $signed({1'b0, op_i.coef_b});
  assign prod_a = sfm_pkg::acc_t'(coef_a) * sfm_pkg::acc_t'(op_i.smp_a);
  assign prod_b = sfm_pkg::acc_t'(coef_b) * sfm_pkg::acc_t'(op_i.smp_b);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= prod_a + prod_b;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

### hdl/stereo_crossfeed_mixer_top.sv
// Stereo crossfeed mixer: when crossfeed is active, the sequencer walks delay RAM read,
// low-pass, wet and blend steps through two shared multiply units before it takes the next
// input frame; in pass-through it goes straight to the output step. Both wait while the output is held.
// The result is held in an output register.
// Reset clears the delay line valid bits, pointer, low-pass states, mix level and registers.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_crossfeed_mixer_top_macros.svh"

module stereo_crossfeed_mixer_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  sfm_in_if.sink                         in_if,
  sfm_out_if.source                      out_if,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sfm_pkg::AddrW-1:0] paddr,
  input  wire logic [sfm_pkg::DataW-1:0] pwdata,
  output logic      [sfm_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  sfm_pkg::cfg_t       cfg;
  sfm_pkg::state_e     state_q, state_d;
  logic                in_fire;
  logic                bypass;
  logic                bypass_q;
  logic                out_free;
  sfm_pkg::sample_t    dry_l_q, dry_r_q;
  sfm_pkg::sample_t    lp_rl_q, lp_lr_q;
  sfm_pkg::sample_t    wet_l_q, wet_r_q;
  sfm_pkg::sample_t    out_l_q, out_r_q;
  logic                out_valid_q;
  logic [sfm_pkg::MixW-1:0] mix_q, mix_d;
  sfm_pkg::ptr_t       wp_q;
  logic                ram_en, ram_we;
  sfm_pkg::ptr_t       ram_addr;
  sfm_pkg::line_word_t ram_wdata, ram_rdata;
  logic                mac_en;
  sfm_pkg::mac_op_t    op_l, op_r;
  sfm_pkg::acc_t       acc_l, acc_r;
  logic signed [17:0]  diff;
  sfm_pkg::acc_t       ramp_round;
  logic signed [17:0]  step;
  logic signed [18:0]  mix_sum;

  sfm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  sfm_delay_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sfm_mac u_mac_l (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .op_i  (op_l),
    .acc_o (acc_l)
  );

  sfm_mac u_mac_r (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .op_i  (op_r),
    .acc_o (acc_r)
  );

  assign in_fire  = in_if.valid && in_if.ready;
  assign bypass   = !cfg.enable && (mix_q == '0);
  assign out_free = !out_valid_q || out_if.ready;
  assign diff     = (cfg.enable ? 18'sd65535 : 18'sd0) - $signed({2'b00, mix_q});

  // Ramp step from the product latched at input transfer, with the one-unit minimum step.
  always_comb begin
    ramp_round = (acc_l + sfm_pkg::acc_t'(32768)) >>> 16;
    step       = ramp_round[17:0];
    if (step == '0 && diff != '0 && cfg.ramp_coeff != '0) begin
      step = diff[17] ? -18'sd1 : 18'sd1;
    end
    mix_sum = $signed({3'b000, mix_q}) + 19'(step);
    if (mix_sum < 0) begin
      mix_d = '0;
    end else if (mix_sum > 19'sd65535) begin
      mix_d = sfm_pkg::MixW'(sfm_pkg::MixFull);
    end else begin
      mix_d = mix_sum[sfm_pkg::MixW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sfm_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = bypass ? sfm_pkg::S_OUT : sfm_pkg::S_LP;
        end
      end
      sfm_pkg::S_LP:      state_d = sfm_pkg::S_LP_SAT;
      sfm_pkg::S_LP_SAT:  state_d = sfm_pkg::S_WET;
      sfm_pkg::S_WET:     state_d = sfm_pkg::S_WET_SAT;
      sfm_pkg::S_WET_SAT: state_d = sfm_pkg::S_BLEND;
      sfm_pkg::S_BLEND:   state_d = sfm_pkg::S_OUT;
      sfm_pkg::S_OUT: begin
        if (out_free) begin
          state_d = sfm_pkg::S_IDLE;
        end
      end
      default: state_d = sfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = wp_q;
    ram_wdata   = {dry_l_q, dry_r_q};
    mac_en      = 1'b0;
    op_l        = '0;
    op_r        = '0;
    case (state_q)
      sfm_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        ram_en      = in_if.valid && !bypass;
        ram_addr    = wp_q - sfm_pkg::PtrW'(cfg.delay_frames);
        mac_en      = in_if.valid && !bypass;
        op_l.coef_a = {1'b0, cfg.ramp_coeff};
        op_l.smp_a  = sfm_pkg::SampleWidth'(diff);
      end
      sfm_pkg::S_LP: begin
        ram_en      = 1'b1;
        ram_we      = 1'b1;
        mac_en      = 1'b1;
        op_l.coef_a = {1'b0, cfg.lowpass_input_gain};
        op_l.smp_a  = ram_rdata[sfm_pkg::SampleWidth-1:0];
        op_l.coef_b = {2'b00, cfg.lowpass_pole};
        op_l.smp_b  = lp_rl_q;
        op_r.coef_a = {1'b0, cfg.lowpass_input_gain};
        op_r.smp_a  = ram_rdata[2*sfm_pkg::SampleWidth-1:sfm_pkg::SampleWidth];
        op_r.coef_b = {2'b00, cfg.lowpass_pole};
        op_r.smp_b  = lp_lr_q;
      end
      sfm_pkg::S_WET: begin
        mac_en      = 1'b1;
        op_l.coef_a = {1'b0, cfg.direct_gain};
        op_l.smp_a  = dry_l_q;
        op_l.coef_b = {1'b0, cfg.cross_gain};
        op_l.smp_b  = lp_rl_q;
        op_r.coef_a = {1'b0, cfg.direct_gain};
        op_r.smp_a  = dry_r_q;
        op_r.coef_b = {1'b0, cfg.cross_gain};
        op_r.smp_b  = lp_lr_q;
      end
      sfm_pkg::S_BLEND: begin
        mac_en      = 1'b1;
        op_l.coef_a = sfm_pkg::CoefW'(sfm_pkg::MixScale) - sfm_pkg::CoefW'(mix_q);
        op_l.smp_a  = dry_l_q;
        op_l.coef_b = sfm_pkg::CoefW'(mix_q);
        op_l.smp_b  = wet_l_q;
        op_r.coef_a = sfm_pkg::CoefW'(sfm_pkg::MixScale) - sfm_pkg::CoefW'(mix_q);
        op_r.smp_a  = dry_r_q;
        op_r.coef_b = sfm_pkg::CoefW'(mix_q);
        op_r.smp_b  = wet_r_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfm_pkg::S_IDLE;
      bypass_q    <= 1'b0;
      mix_q       <= '0;
      wp_q        <= '0;
      lp_rl_q     <= '0;
      lp_lr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        bypass_q <= bypass;
      end
      if (state_q == sfm_pkg::S_LP) begin
        mix_q <= mix_d;
      end
      if (state_q == sfm_pkg::S_LP_SAT) begin
        wp_q    <= wp_q + sfm_pkg::PtrW'(1);
        lp_rl_q <= sfm_pkg::round_sat(acc_l, 15);
        lp_lr_q <= sfm_pkg::round_sat(acc_r, 15);
      end
      if (state_q == sfm_pkg::S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dry_l_q <= in_if.left_in;
      dry_r_q <= in_if.right_in;
    end
    if (state_q == sfm_pkg::S_WET_SAT) begin
      wet_l_q <= sfm_pkg::round_sat(acc_l, 15);
      wet_r_q <= sfm_pkg::round_sat(acc_r, 15);
    end
    if (state_q == sfm_pkg::S_OUT && out_free) begin
      out_l_q <= bypass_q ? dry_l_q : sfm_pkg::round_sat(acc_l, 16);
      out_r_q <= bypass_q ? dry_r_q : sfm_pkg::round_sat(acc_r, 16);
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.left_out  = out_l_q;
  assign out_if.right_out = out_r_q;

  `SFM_ASSERT_NXT(a_bypass_skips_work, in_fire && bypass, state_q == sfm_pkg::S_OUT,
                  "bypass frame did not go straight to output")
  `SFM_ASSERT_NXT(a_mix_only_in_lp, state_q != sfm_pkg::S_LP, $stable(mix_q),
                  "mix level changed outside the ramp step")
  `SFM_ASSERT_NXT(a_wp_only_in_lpsat, state_q != sfm_pkg::S_LP_SAT, $stable(wp_q),
                  "write pointer moved outside its step")
  `SFM_ASSERT_NXT(a_ramp_out_falls, !cfg.enable && state_q == sfm_pkg::S_LP,
                  mix_q <= $past(mix_q), "mix level rose while disabled")
  `SFM_ASSERT_IMP(a_ram_write_in_lp, ram_en && ram_we, state_q == sfm_pkg::S_LP,
                  "delay line written outside the write step")

endmodule

`default_nettype wire

### sim/stereo_crossfeed_mixer_top_tb.sv
// Self-checking testbench for stereo_crossfeed_mixer_top: directed and random stereo frames
// under random stalls, checked against a cycle-free predictor of the crossfeed arithmetic.
// Depends on sfm_pkg, sfm_in_if, sfm_out_if and the mixer RTL.
`timescale 1ns / 1ps

module stereo_crossfeed_mixer_top_tb;
  import sfm_pkg::*;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  localparam sample_t PosFull = sample_t'(24'h7FFFFF);
  localparam sample_t NegFull = sample_t'(24'h800000);
  localparam longint  SatHi   = 64'sd8388607;
  localparam longint  SatLo   = -64'sd8388608;
  localparam longint  MixTop  = 64'sd65535;
  localparam longint  MixUnit = 64'sd65536;

  class crossfeed_scoreboard;
    cfg_t        cfg;
    longint      r2l_line [DelayDepth];
    longint      l2r_line [DelayDepth];
    int unsigned wr_ptr;
    longint      r2l_lp;
    longint      l2r_lp;
    longint      mix;
    frame_t      expected_frames [$];
    int unsigned failures;

    function new();
      cfg.enable             = 1'b0;
      cfg.direct_gain        = 16'd32768;
      cfg.cross_gain         = 16'd0;
      cfg.lowpass_input_gain = 16'd32768;
      cfg.lowpass_pole       = 15'd0;
      cfg.delay_frames       = 6'd0;
      cfg.ramp_coeff         = 16'd4096;
      foreach (r2l_line[i]) begin
        r2l_line[i] = 0;
        l2r_line[i] = 0;
      end
      wr_ptr   = 0;
      r2l_lp   = 0;
      l2r_lp   = 0;
      mix      = 0;
      failures = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_ENABLE:      cfg.enable             = value[0];
        REG_DIRECT_GAIN: cfg.direct_gain        = value[15:0];
        REG_CROSS_GAIN:  cfg.cross_gain         = value[15:0];
        REG_LP_GAIN:     cfg.lowpass_input_gain = value[15:0];
        REG_LP_POLE:     cfg.lowpass_pole       = value[14:0];
        REG_DELAY:       cfg.delay_frames       = value[5:0];
        REG_RAMP_COEFF:  cfg.ramp_coeff         = value[15:0];
        default: ;
      endcase
    endfunction

    function longint sat_q23(longint value);
      if (value > SatHi) return SatHi;
      if (value < SatLo) return SatLo;
      return value;
    endfunction

    // Round half up, then floor division by 2**shift.
    function longint round_div(longint value, int unsigned shift);
      return (value + (longint'(1) << (shift - 1))) >>> shift;
    endfunction

    function void predict_frame(sample_t lval, sample_t rval);
      longint      dry_l;
      longint      dry_r;
      longint      dly_l;
      longint      dly_r;
      longint      wet_l;
      longint      wet_r;
      longint      ramp_goal;
      longint      ramp_gap;
      longint      ramp_delta;
      int unsigned rd;
      frame_t      res;
      dry_l = longint'(lval);
      dry_r = longint'(rval);
      if (!cfg.enable && mix == 0) begin
        res.left  = lval;
        res.right = rval;
        expected_frames.push_back(res);
        return;
      end
      rd = (wr_ptr + DelayDepth - cfg.delay_frames) % DelayDepth;
      dly_r = r2l_line[rd];
      dly_l = l2r_line[rd];
      r2l_line[wr_ptr] = dry_r;
      l2r_line[wr_ptr] = dry_l;
      wr_ptr = (wr_ptr + 1) % DelayDepth;
      r2l_lp = sat_q23(round_div(longint'(cfg.lowpass_input_gain) * dly_r
                                 + longint'(cfg.lowpass_pole) * r2l_lp, 15));
      l2r_lp = sat_q23(round_div(longint'(cfg.lowpass_input_gain) * dly_l
                                 + longint'(cfg.lowpass_pole) * l2r_lp, 15));
      wet_l = sat_q23(round_div(longint'(cfg.direct_gain) * dry_l
                                + longint'(cfg.cross_gain) * r2l_lp, 15));
      wet_r = sat_q23(round_div(longint'(cfg.direct_gain) * dry_r
                                + longint'(cfg.cross_gain) * l2r_lp, 15));
      ramp_goal  = cfg.enable ? MixTop : 0;
      ramp_gap   = ramp_goal - mix;
      ramp_delta = round_div(ramp_gap * longint'(cfg.ramp_coeff), 16);
      if (ramp_delta == 0 && ramp_gap != 0 && cfg.ramp_coeff != 0) begin
        ramp_delta = (ramp_gap > 0) ? 1 : -1;
      end
      mix = mix + ramp_delta;
      if (mix < 0) mix = 0;
      if (mix > MixTop) mix = MixTop;
      res.left  = sample_t'(sat_q23(round_div(dry_l * (MixUnit - mix) + wet_l * mix, 16)));
      res.right = sample_t'(sat_q23(round_div(dry_r * (MixUnit - mix) + wet_r * mix, 16)));
      expected_frames.push_back(res);
    endfunction

    function void compare_field(string name, sample_t want, sample_t got);
      if (want !== got) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
      end
    endfunction

    function void check_frame(sample_t lval, sample_t rval);
      frame_t want;
      if (expected_frames.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: output frame with none expected, left %0d right %0d",
                   $realtime, lval, rval);
        end
        return;
      end
      want = expected_frames.pop_front();
      compare_field("left_out", want.left, lval);
      compare_field("right_out", want.right, rval);
    endfunction

    function bit pending();
      return expected_frames.size() != 0;
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_request = 0;
  int unsigned stall_left    = 0;

  crossfeed_scoreboard sb = new();

  sfm_in_if  in_bus ();
  sfm_out_if out_bus ();

  stereo_crossfeed_mixer_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_frame(out_bus.left_out, out_bus.right_out);
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(logic en, logic [15:0] dg, logic [15:0] cg, logic [15:0] lg,
                              logic [14:0] lp, logic [5:0] dl, logic [15:0] rc);
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_DIRECT_GAIN, 32'(dg));
    write_reg(REG_CROSS_GAIN, 32'(cg));
    write_reg(REG_LP_GAIN, 32'(lg));
    write_reg(REG_LP_POLE, 32'(lp));
    write_reg(REG_DELAY, 32'(dl));
    write_reg(REG_RAMP_COEFF, 32'(rc));
  endtask

  function automatic int unsigned pick_coeff(int unsigned top);
    case ($urandom_range(4))
      0:       return 0;
      1:       return top;
      2:       return (top + 1) / 2;
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic random_config();
    apply_config($urandom_range(99) < 75, 16'(pick_coeff(65535)), 16'(pick_coeff(65535)),
                 16'(pick_coeff(65535)), 15'(pick_coeff(32767)), 6'(pick_coeff(63)),
                 16'(pick_coeff(65535)));
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return PosFull;
      1:       return NegFull;
      2, 3:    return sample_t'(int'($urandom_range(511)) - 256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic send_frame(sample_t lval, sample_t rval);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.left_in  <= lval;
    in_bus.right_in <= rval;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    sb.predict_frame(lval, rval);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (sb.pending()) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n_items;
    rst_ni          <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.left_in  <= '0;
    in_bus.right_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: disabled with a settled ramp, so frames pass through.
    send_frame(PosFull, NegFull);
    send_frame(NegFull, PosFull);
    send_frame(sample_t'(0), sample_t'(0));
    send_frame(sample_t'(-1), sample_t'(1));
    drain_results();

    // Cross and LP gains near 2.0, max pole, no delay and fastest ramp drive saturation.
    apply_config(1'b1, 16'd32768, 16'd65535, 16'd65535, 15'd32767, 6'd0, 16'd65535);
    send_frame(PosFull, PosFull);
    send_frame(NegFull, NegFull);
    send_frame(PosFull, NegFull);
    send_frame(NegFull, PosFull);
    send_frame(sample_t'(0), sample_t'(0));
    send_frame(sample_t'(1), sample_t'(-1));
    drain_results();

    // Longest delay and a ramp step that rounds to zero, forcing single-unit steps.
    apply_config(1'b1, 16'd65535, 16'd32768, 16'd32768, 15'd0, 6'd63, 16'd1);
    repeat (5) send_frame(rand_sample(), rand_sample());
    drain_results();

    // A zero ramp coefficient freezes the mix level.
    apply_config(1'b1, 16'd32768, 16'd16384, 16'd16384, 15'd16384, 6'd5, 16'd0);
    repeat (3) send_frame(rand_sample(), rand_sample());
    drain_results();

    // Ramp out until settled, after which frames pass through and the state freezes.
    apply_config(1'b0, 16'd32768, 16'd16384, 16'd16384, 15'd16384, 6'd5, 16'd65535);
    repeat (5) send_frame(rand_sample(), rand_sample());
    drain_results();

    for (int ph = 0; ph < 15; ph++) begin
      send_idle_pct = (ph < 5) ? 19 : (ph < 10) ? 81 : 0;
      recv_idle_pct = (ph < 5) ? 81 : (ph < 10) ? 19 : 0;
      case (ph)
        0:       apply_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 6'h3F, 16'hFFFF);
        1:       apply_config(1'b1, 16'h0, 16'h0, 16'h0, 15'h0, 6'h0, 16'h0);
        default: random_config();
      endcase
      n_items = $urandom_range(30, 70);
      for (int i = 0; i < n_items; i++) begin
        if (ph % 4 == 1 && i == n_items / 2) drain_results();
        if (ph == 12 && i == 5) stall_request = 400;
        send_frame(rand_sample(), rand_sample());
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && !sb.pending()) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
